/* rtl/srbs_pkg.sv */
// shared types and constants of the shift register bus sequencer
`timescale 1ns / 1ps
package srbs_pkg;

	localparam int STAGES     = 16;
	localparam int HALF       = 8;
	localparam int BUSES      = 3;
	localparam int GAIN_W     = 11;
	localparam int SCALED_W   = 19;
	localparam int CV_W       = 22;
	localparam int FIFO_DEPTH = 4;

	localparam logic [GAIN_W-1:0] GAIN_MAX = 11'd1280;
	localparam logic [CV_W-1:0]   CV_MAX   = 22'd2611200;

	typedef enum logic [1:0] {
		KIND_RISE = 2'd0,
		KIND_FALL = 2'd1,
		KIND_LOAD = 2'd2,
		KIND_TICK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_LOAD_PATTERN = 3'd0,
		REG_BUS_MAP      = 3'd1,
		REG_PITCH_LOW    = 3'd2,
		REG_PITCH_HIGH   = 3'd3,
		REG_MODE_FLAGS   = 3'd4,
		REG_PULSE_TICKS  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [BUSES-1:0] merge;
		logic             reload;
		logic             bus1_and;
		logic             invert;
		logic             random;
		logic             split;
	} mode_t;

	typedef struct packed {
		logic [STAGES-1:0]   load_pattern;
		logic [2*STAGES-1:0] bus_map;
		mode_t               mode;
		logic [15:0]         pulse_ticks;
	} front_cfg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic              rise;
		logic [GAIN_W-1:0] gain;
		logic [BUSES-1:0]  gates;
		logic [BUSES-1:0]  trigs;
		logic [STAGES-1:0] pattern;
	} entry_t;

endpackage

/* rtl/shift_register_bus_sequencer.sv */
// top level of the sixteen stage shift register bus sequencer
`timescale 1ns / 1ps
//  port group   direction  handshake          carries
//  item in      in         push / full        kind, random_word, random_threshold, range_gain
//  item out     out        empty / pop        gates, trigger_levels, cv_*, stage_bits
//  config       in         cfg_we             cfg_index, cfg_wdata
//
//  one item per cycle in and out unless full is up or the output waits for pop; the front
//  updates all sequencer state in the cycle it takes an item, so items may follow back to back
//  a result passes from its queue slot to the product stage, then to the result register
//  where cv sums are added and saturated
//  full rises only when the four entry queue and the back are all held by pop
//  reset clears the pattern, buses, gates, pulses, held cv and the queue;
//  registers return to their power-up values
module shift_register_bus_sequencer #(
	parameter int KNOB_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// item in
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic [15:0] random_word,
	input  logic [16:0] random_threshold,
	input  logic [10:0] range_gain,
	// item out
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  gates,
	output logic [2:0]  trigger_levels,
	output logic [21:0] cv_first,
	output logic [21:0] cv_second,
	output logic [22:0] cv_total,
	output logic signed [22:0] cv_difference,
	output logic [15:0] stage_bits,
	// register writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	// configuration registers
	logic [15:0] load_pattern_q;
	logic [31:0] bus_map_q;
	logic [63:0] pitch_low_q, pitch_high_q;
	logic [7:0]  mode_q;
	logic [15:0] pulse_ticks_q;

	srbs_pkg::front_cfg_t front_cfg;
	srbs_pkg::entry_t     wr_entry, head;
	logic                 take, head_valid, head_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pattern_q <= '0;
			bus_map_q      <= '0;
			pitch_low_q    <= 64'h2020_2020_2020_2020;
			pitch_high_q   <= 64'h2020_2020_2020_2020;
			mode_q         <= '0;
			pulse_ticks_q  <= 16'd48;
		end else if (cfg_we) begin
			unique case (srbs_pkg::cfg_reg_t'(cfg_index))
				srbs_pkg::REG_LOAD_PATTERN: load_pattern_q <= cfg_wdata[15:0];
				srbs_pkg::REG_BUS_MAP:      bus_map_q      <= cfg_wdata[31:0];
				srbs_pkg::REG_PITCH_LOW:    pitch_low_q    <= cfg_wdata;
				srbs_pkg::REG_PITCH_HIGH:   pitch_high_q   <= cfg_wdata;
				srbs_pkg::REG_MODE_FLAGS:   mode_q         <= cfg_wdata[7:0];
				srbs_pkg::REG_PULSE_TICKS:  pulse_ticks_q  <= cfg_wdata[15:0];
				// unused register indexes are dropped
				default: mode_q <= mode_q;
			endcase
		end
	end

	assign front_cfg.load_pattern = load_pattern_q;
	assign front_cfg.bus_map      = bus_map_q;
	assign front_cfg.mode         = srbs_pkg::mode_t'(mode_q);
	assign front_cfg.pulse_ticks  = pulse_ticks_q;

	// an item is taken whenever the queue has room, regardless of the output side
	assign take = push && !full;

	srbs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.kind             (kind),
		.random_word      (random_word),
		.random_threshold (random_threshold),
		.range_gain       (range_gain),
		.cfg              (front_cfg),
		.entry            (wr_entry)
	);

	srbs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take),
		.wr_data  (wr_entry),
		.full     (full),
		.rd_en    (head_pop),
		.rd_data  (head),
		.has_item (head_valid)
	);

	srbs_back #(
		.KNOB_BITS (KNOB_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head             (head),
		.head_pop         (head_pop),
		.pitch_low_knobs  (pitch_low_q),
		.pitch_high_knobs (pitch_high_q),
		.pop              (pop),
		.empty            (empty),
		.gates            (gates),
		.trigger_levels   (trigger_levels),
		.cv_first         (cv_first),
		.cv_second        (cv_second),
		.stage_bits       (stage_bits)
	);

	// sum and difference straight off the held cv registers
	assign cv_total      = {1'b0, cv_first} + {1'b0, cv_second};
	assign cv_difference = signed'({1'b0, cv_first} - {1'b0, cv_second});

endmodule

/* rtl/srbs_front.sv */
// front: event decode, pattern rotation, bus mapping, gates and trigger pulses
`timescale 1ns / 1ps
module srbs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [1:0]                    kind,
	input  logic [15:0]                   random_word,
	input  logic [16:0]                   random_threshold,
	input  logic [srbs_pkg::GAIN_W-1:0]   range_gain,
	input  srbs_pkg::front_cfg_t          cfg,
	output srbs_pkg::entry_t              entry
);

	logic [srbs_pkg::STAGES-1:0] pat_q, pat_n, rot;
	logic [srbs_pkg::BUSES-1:0]  bus_q, bus_n, bus_new, raw;
	logic [srbs_pkg::BUSES-1:0]  gate_q, gate_n, trig_q, trig_n;
	logic [15:0]                 cnt_q [srbs_pkg::BUSES];
	logic [15:0]                 cnt_n [srbs_pkg::BUSES];
	logic                        rnd_bit, fb_lo, reload;
	logic [srbs_pkg::GAIN_W-1:0] gain_sat;

	assign rnd_bit  = {1'b0, random_word} < random_threshold;
	assign gain_sat = (range_gain > srbs_pkg::GAIN_MAX) ? srbs_pkg::GAIN_MAX : range_gain;

	always_comb begin
		if (cfg.mode.split) begin
			fb_lo = cfg.mode.random ? rnd_bit : pat_q[7];
			rot   = {pat_q[14:8], pat_q[15] ^ cfg.mode.invert, pat_q[6:0], fb_lo};
		end else begin
			fb_lo = cfg.mode.random ? rnd_bit : pat_q[15];
			rot   = {pat_q[14:0], fb_lo};
		end
	end

	// stage to bus fan-in, code 3 lands on bus 2
	always_comb begin
		raw = '0;
		for (int k = 0; k < srbs_pkg::STAGES; k++) begin
			raw[0] = raw[0] | (rot[k] & (cfg.bus_map[2*k +: 2] == 2'd0));
			raw[1] = raw[1] | (rot[k] & (cfg.bus_map[2*k +: 2] == 2'd1));
			raw[2] = raw[2] | (rot[k] & cfg.bus_map[2*k+1]);
		end
		bus_new[0] = raw[0];
		bus_new[2] = raw[2];
		bus_new[1] = cfg.mode.bus1_and ? (raw[0] & raw[2]) : (raw[1] & ~(raw[0] | raw[2]));
		reload     = cfg.mode.reload & ~bus_q[0] & raw[0];
	end

	always_comb begin
		pat_n  = pat_q;
		bus_n  = bus_q;
		gate_n = gate_q;
		trig_n = trig_q;
		cnt_n  = cnt_q;
		unique case (srbs_pkg::kind_t'(kind))
			srbs_pkg::KIND_RISE: begin
				pat_n  = reload ? cfg.load_pattern : rot;
				bus_n  = bus_new;
				gate_n = bus_new;
				trig_n = trig_q | bus_new;
				for (int k = 0; k < srbs_pkg::BUSES; k++) begin
					if (bus_new[k]) begin
						cnt_n[k] = cfg.pulse_ticks;
					end
				end
			end
			srbs_pkg::KIND_FALL: begin
				gate_n = gate_q & bus_q & cfg.mode.merge;
			end
			srbs_pkg::KIND_LOAD: begin
				pat_n = cfg.load_pattern;
			end
			srbs_pkg::KIND_TICK: begin
				for (int k = 0; k < srbs_pkg::BUSES; k++) begin
					if (trig_q[k]) begin
						if (cnt_q[k] <= 16'd1) begin
							cnt_n[k]  = '0;
							trig_n[k] = 1'b0;
						end else begin
							cnt_n[k] = cnt_q[k] - 16'd1;
						end
					end
				end
			end
			default: begin
				pat_n = pat_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			bus_q  <= '0;
			gate_q <= '0;
			trig_q <= '0;
			for (int k = 0; k < srbs_pkg::BUSES; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (take) begin
			pat_q  <= pat_n;
			bus_q  <= bus_n;
			gate_q <= gate_n;
			trig_q <= trig_n;
			cnt_q  <= cnt_n;
		end
	end

	assign entry.rise    = (srbs_pkg::kind_t'(kind) == srbs_pkg::KIND_RISE);
	assign entry.gain    = gain_sat;
	assign entry.gates   = gate_n;
	assign entry.trigs   = trig_n;
	assign entry.pattern = pat_n;

	// a gate only stays up on a bus that is up
	a_gate_in_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(gate_q & ~bus_q) == '0)
		else $error("gate high on a low bus");

	// an idle pulse channel keeps its counter at zero
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(trig_q[0] || cnt_q[0] == '0) && (trig_q[1] || cnt_q[1] == '0)
		&& (trig_q[2] || cnt_q[2] == '0))
		else $error("pulse counter running without trigger");

endmodule

/* rtl/srbs_fifo.sv */
// short queue of classified items between front and back
`timescale 1ns / 1ps
module srbs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  srbs_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output srbs_pkg::entry_t rd_data,
	output logic             has_item
);

	localparam int PtrW = $clog2(srbs_pkg::FIFO_DEPTH);
	localparam int CntW = $clog2(srbs_pkg::FIFO_DEPTH + 1);

	srbs_pkg::entry_t mem [srbs_pkg::FIFO_DEPTH];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]  cnt_q;

	assign full     = (cnt_q == CntW'(srbs_pkg::FIFO_DEPTH));
	assign has_item = (cnt_q != '0);
	assign rd_data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
			end
			if (rd_en) begin
				rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
			end
			// count holds when both or neither side moves
			if (wr_en && !rd_en) begin
				cnt_q <= CntW'(cnt_q + 1'b1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= CntW'(cnt_q - 1'b1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full) && !(rd_en && !has_item))
		else $error("queue written when full or read when empty");

endmodule

/* rtl/srbs_back.sv */
// back: knob times gain products, cv sums, held cv and result register
`timescale 1ns / 1ps
module srbs_back #(
	parameter int KNOB_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  srbs_pkg::entry_t            head,
	output logic                        head_pop,
	input  logic [63:0]                 pitch_low_knobs,
	input  logic [63:0]                 pitch_high_knobs,
	input  logic                        pop,
	output logic                        empty,
	output logic [srbs_pkg::BUSES-1:0]  gates,
	output logic [srbs_pkg::BUSES-1:0]  trigger_levels,
	output logic [srbs_pkg::CV_W-1:0]   cv_first,
	output logic [srbs_pkg::CV_W-1:0]   cv_second,
	output logic [srbs_pkg::STAGES-1:0] stage_bits
);

	localparam int ExtW  = 64 + srbs_pkg::HALF * KNOB_BITS;
	localparam int WideW = KNOB_BITS + srbs_pkg::SCALED_W;
	localparam int Shr   = (KNOB_BITS > 8) ? KNOB_BITS - 8 : 0;
	localparam int Shl   = (KNOB_BITS < 8) ? 8 - KNOB_BITS : 0;

	logic [ExtW-1:0] ext_lo, ext_hi;
	logic [srbs_pkg::SCALED_W-1:0] prod_c  [srbs_pkg::STAGES];
	logic [srbs_pkg::SCALED_W-1:0] prod_s1 [srbs_pkg::STAGES];
	logic                          valid_s1, rise_s1;
	logic [srbs_pkg::BUSES-1:0]    gates_s1, trigs_s1;
	logic [srbs_pkg::STAGES-1:0]   pat_s1;
	logic                          out_valid_q, out_ready, s1_ready;
	logic [srbs_pkg::CV_W-1:0]     sum_lo, sum_hi, sat_lo, sat_hi;
	logic [srbs_pkg::CV_W-1:0]     held_first_q, held_second_q;
	logic [srbs_pkg::BUSES-1:0]    gates_q, trigs_q;
	logic [srbs_pkg::STAGES-1:0]   bits_q;

	// lanes past bit 63 read as zero
	assign ext_lo = {{(srbs_pkg::HALF * KNOB_BITS){1'b0}}, pitch_low_knobs};
	assign ext_hi = {{(srbs_pkg::HALF * KNOB_BITS){1'b0}}, pitch_high_knobs};

	for (genvar g = 0; g < srbs_pkg::STAGES; g++) begin : g_prod
		localparam int Lane = g % srbs_pkg::HALF;
		logic [KNOB_BITS-1:0] knob;
		logic [WideW-1:0]     wide, scaled;
		if (g < srbs_pkg::HALF) begin : g_lo
			assign knob = ext_lo[Lane*KNOB_BITS +: KNOB_BITS];
		end else begin : g_hi
			assign knob = ext_hi[Lane*KNOB_BITS +: KNOB_BITS];
		end
		assign wide      = WideW'(knob) * WideW'(head.gain);
		assign scaled    = (wide >> Shr) << Shl;
		assign prod_c[g] = head.pattern[g] ? scaled[srbs_pkg::SCALED_W-1:0] : '0;
	end

	assign out_ready = !out_valid_q || pop;
	assign s1_ready  = !valid_s1 || out_ready;
	assign head_pop  = head_valid && s1_ready;

	always_comb begin
		sum_lo = '0;
		sum_hi = '0;
		for (int k = 0; k < srbs_pkg::HALF; k++) begin
			sum_lo = sum_lo + srbs_pkg::CV_W'(prod_s1[k]);
			sum_hi = sum_hi + srbs_pkg::CV_W'(prod_s1[k + srbs_pkg::HALF]);
		end
		sat_lo = (sum_lo > srbs_pkg::CV_MAX) ? srbs_pkg::CV_MAX : sum_lo;
		sat_hi = (sum_hi > srbs_pkg::CV_MAX) ? srbs_pkg::CV_MAX : sum_hi;
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			prod_s1  <= prod_c;
			rise_s1  <= head.rise;
			gates_s1 <= head.gates;
			trigs_s1 <= head.trigs;
			pat_s1   <= head.pattern;
		end
		if (out_ready && valid_s1) begin
			gates_q <= gates_s1;
			trigs_q <= trigs_s1;
			bits_q  <= pat_s1;
		end
	end

	// held cv equals the cv of the newest rise item that entered the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			held_first_q  <= '0;
			held_second_q <= '0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= head_valid;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
			if (out_ready && valid_s1 && rise_s1) begin
				held_first_q  <= sat_lo;
				held_second_q <= sat_hi;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign gates          = gates_q;
	assign trigger_levels = trigs_q;
	assign cv_first       = held_first_q;
	assign cv_second      = held_second_q;
	assign stage_bits     = bits_q;

	a_cv_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_first_q <= srbs_pkg::CV_MAX && held_second_q <= srbs_pkg::CV_MAX)
		else $error("held cv above saturation");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(held_first_q)
		&& $stable(bits_q))
		else $error("waiting item lost or changed");

endmodule
